[rtl/assert_macros.svh]
// Assertion macros for the RTL of the retention list.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BSTR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BSTR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define BSTR_ASSERT(lbl, clk, rst_n, prop)
`define BSTR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/bstr_pkg.sv]
`timescale 1ns / 1ps
// Types and constants for the bounded sorted retention list.
// No dependencies.
package bstr_pkg;

    // slot index width covering the largest built capacity (4096 entries)
    localparam int SLOT_W  = 12;
    localparam int DIST_W  = 32;
    localparam int TAG_W   = 32;
    localparam int LIMIT_W = 9;
    localparam int HELD_W  = 9;
    localparam int GROUP_SZ = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // broadcast from the control logic to every cell
    typedef struct packed {
        logic              ins;
        logic              rd;
        logic              grow;
        logic [DIST_W-1:0] distance;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] rslot;
    } bcast_t;

    // per-cell result contribution, OR-combined across the row
    typedef struct packed {
        logic              acc;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] distance;
        logic [TAG_W-1:0]  tag;
        logic              evalid;
    } rec_t;

endpackage

[rtl/bstr_cell.sv]
`timescale 1ns / 1ps
// One list cell: holds a (distance, tag) entry and an occupied flag.
// Depends on bstr_pkg.
module bstr_cell #(
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bstr_pkg::bcast_t             bc,
    input  logic [bstr_pkg::DIST_W-1:0]  prev_dist,
    input  logic [bstr_pkg::TAG_W-1:0]   prev_tag,
    input  logic                         prev_gt,
    input  logic                         prev_valid,
    output logic [bstr_pkg::DIST_W-1:0]  distance,
    output logic [bstr_pkg::TAG_W-1:0]   tag,
    output logic                         gt,
    output logic                         valid,
    output bstr_pkg::rec_t               rec
);

    localparam logic [bstr_pkg::SLOT_W-1:0] MY_SLOT = bstr_pkg::SLOT_W'(INDEX);

    logic [bstr_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [bstr_pkg::TAG_W-1:0]  tag_reg, tag_next;
    logic                        valid_reg, valid_next;
    logic                        take;
    logic                        shift;
    logic                        hit;

    // entries are ascending, so gt is a suffix of the occupied cells
    assign gt    = valid_reg && (dist_reg > bc.distance);
    // first greater entry, or first free cell on an append
    assign take  = bc.ins && !prev_gt &&
                   (gt || (!valid_reg && prev_valid && bc.grow));
    assign shift = bc.ins && prev_gt;
    assign hit   = bc.rd && valid_reg && (bc.rslot == MY_SLOT);

    always_comb
    begin
        dist_next  = dist_reg;
        tag_next   = tag_reg;
        valid_next = valid_reg | (bc.grow && prev_valid);
        priority if (take)
        begin
            dist_next = bc.distance;
            tag_next  = bc.tag;
        end
        else if (shift)
        begin
            dist_next = prev_dist;
            tag_next  = prev_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        tag_reg  <= tag_next;
    end

    assign distance = dist_reg;
    assign tag      = tag_reg;
    assign valid    = valid_reg;

    always_comb
    begin
        rec.acc      = take;
        rec.slot     = take ? MY_SLOT : '0;
        rec.distance = hit ? dist_reg : '0;
        rec.tag      = hit ? tag_reg : '0;
        rec.evalid   = hit;
    end

endmodule

[rtl/bstr_gather.sv]
`timescale 1ns / 1ps
// Registered OR-combine of one group of cell contributions.
// Depends on bstr_pkg.
module bstr_gather #(
    parameter int N = 16
) (
    input  logic           clk,
    input  logic           load,
    input  bstr_pkg::rec_t recs [N],
    output bstr_pkg::rec_t grp
);

    bstr_pkg::rec_t grp_reg, grp_next;

    always_comb
    begin
        grp_next = '0;
        for (int i = 0; i < N; i++)
            grp_next = grp_next | recs[i];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp_next;
    end

    assign grp = grp_reg;

endmodule

[rtl/bounded_sorted_topk_retention.sv]
`timescale 1ns / 1ps
// Top level of the bounded sorted retention list.
// Depends on bstr_pkg, bstr_cell, bstr_gather and assert_macros.svh.
//
// Keeps up to keep_limit (distance, tag) samples in ascending, stable order
// in a row of MAX_KEEP cells. Each cell compares the incoming distance with
// its own entry and either keeps it, takes the new sample or takes its
// left neighbour's entry, so an insert completes in the cycle it is taken.
// Input channel s_*: s_tuser is the operation (insert or read), s_tdata
// the sample and read slot. Output channel m_*: one result transaction per
// input transaction. cfg_*: write of keep_limit, always ready; write it
// only while the block is idle.
// Results pass two register stages; the first OR-combines cell results in
// groups of 16, the second merges the groups into the output register.
// The block takes one transaction per cycle as long as a low m_tready
// does not hold a result back in the output register.
// Reset empties the list and sets keep_limit to 256.
// While m_tready is low the result waits in the output register, one more
// transaction is taken into the group stage, then s_tready drops.
`include "assert_macros.svh"
module bounded_sorted_topk_retention #(
    parameter int MAX_KEEP = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // new_distance[31:0], new_tag[63:32], read_slot[71:64]
    input  logic [71:0] s_tdata,
    // operation[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], insert_slot[8:1], entry_distance[40:9], entry_tag[72:41],
    // entry_valid[73], held_count[82:74], zero[87:83]
    output logic [87:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int LW = (CW > bstr_pkg::LIMIT_W) ? CW : bstr_pkg::LIMIT_W;
    localparam int NG = (MAX_KEEP + bstr_pkg::GROUP_SZ - 1) / bstr_pkg::GROUP_SZ;

    logic [bstr_pkg::LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [LW-1:0]                lim_eff;
    logic [LW-1:0]                lim_ext;
    logic                         fire;
    logic                         mv;
    logic                         s1_vld_reg;
    logic [bstr_pkg::HELD_W-1:0]  s1_held_reg;
    logic                         out_vld_reg;
    bstr_pkg::rec_t               out_rec_reg, out_rec_next;
    logic [bstr_pkg::HELD_W-1:0]  out_held_reg;
    bstr_pkg::bcast_t             bc;

    logic [bstr_pkg::DIST_W-1:0]  dist_w  [MAX_KEEP];
    logic [bstr_pkg::TAG_W-1:0]   tag_w   [MAX_KEEP];
    logic [MAX_KEEP-1:0]          gt_w;
    logic [MAX_KEEP-1:0]          valid_w;
    logic [MAX_KEEP-1:0]          take_w;
    bstr_pkg::rec_t               rec_w   [MAX_KEEP];
    bstr_pkg::rec_t               grp_w   [NG];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= bstr_pkg::LIMIT_W'(256);
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    assign lim_ext = LW'(limit_reg);

    always_comb
    begin
        priority if (limit_reg == '0)
            lim_eff = LW'(1);
        else if (lim_ext > LW'(MAX_KEEP))
            lim_eff = LW'(MAX_KEEP);
        else
            lim_eff = lim_ext;
    end

    // handshake
    assign mv       = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || mv;
    assign fire     = s_tvalid && s_tready;

    always_comb
    begin
        bc.ins      = fire && (s_tuser[0] == bstr_pkg::OP_INSERT);
        bc.rd       = fire && (s_tuser[0] == bstr_pkg::OP_READ);
        bc.grow     = bc.ins && (LW'(cnt_reg) < lim_eff);
        bc.distance = s_tdata[31:0];
        bc.tag      = s_tdata[63:32];
        bc.rslot    = bstr_pkg::SLOT_W'(s_tdata[71:64]);
    end

    assign cnt_next = cnt_reg + CW'(bc.grow);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // row of cells
    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            bstr_cell #(.INDEX(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .bc         (bc),
                .prev_dist  ('0),
                .prev_tag   ('0),
                .prev_gt    (1'b0),
                .prev_valid (1'b1),
                .distance   (dist_w[i]),
                .tag        (tag_w[i]),
                .gt         (gt_w[i]),
                .valid      (valid_w[i]),
                .rec        (rec_w[i])
            );
        end
        else
        begin : g_body
            bstr_cell #(.INDEX(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .bc         (bc),
                .prev_dist  (dist_w[i-1]),
                .prev_tag   (tag_w[i-1]),
                .prev_gt    (gt_w[i-1]),
                .prev_valid (valid_w[i-1]),
                .distance   (dist_w[i]),
                .tag        (tag_w[i]),
                .gt         (gt_w[i]),
                .valid      (valid_w[i]),
                .rec        (rec_w[i])
            );
        end
        assign take_w[i] = rec_w[i].acc;
    end

    // group stage
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        localparam int LO = g * bstr_pkg::GROUP_SZ;
        localparam int N  = (g == NG - 1) ? (MAX_KEEP - LO) : bstr_pkg::GROUP_SZ;
        bstr_gather #(.N(N)) u_gather (
            .clk  (clk),
            .load (fire),
            .recs (rec_w[LO:LO+N-1]),
            .grp  (grp_w[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (fire)
            s1_vld_reg <= 1'b1;
        else if (mv)
            s1_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            s1_held_reg <= bstr_pkg::HELD_W'(LW'(cnt_next));
    end

    // merge stage into the output register
    always_comb
    begin
        out_rec_next = '0;
        for (int g = 0; g < NG; g++)
            out_rec_next = out_rec_next | grp_w[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (mv)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mv)
        begin
            out_rec_reg  <= out_rec_next;
            out_held_reg <= s1_held_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_held_reg, out_rec_reg.evalid, out_rec_reg.tag,
                       out_rec_reg.distance, out_rec_reg.slot[7:0], out_rec_reg.acc};

    `BSTR_ASSERT(a_cnt_max, clk, rst_n, (cnt_reg <= CW'(MAX_KEEP)))
    `BSTR_ASSERT(a_occ_matches_cnt, clk, rst_n, ($countones(valid_w) == int'(cnt_reg)))
    `BSTR_ASSERT(a_one_taker, clk, rst_n, $onehot0(take_w))
    `BSTR_ASSERT(a_grow_counts, clk, rst_n, bc.grow |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
    `BSTR_ASSERT(a_read_no_take, clk, rst_n, bc.rd |-> (take_w == '0))

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for bounded_sorted_topk_retention: directed and random
// inserts and reads over several keep limits, checked against a predictor.
// Depends on bstr_pkg and the RTL of the retention list.
module tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // new_distance[31:0], new_tag[63:32], read_slot[71:64]
    logic [71:0] s_tdata;
    // operation[0]
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // accepted[0], insert_slot[8:1], entry_distance[40:9], entry_tag[72:41],
    // entry_valid[73], held_count[82:74], zero[87:83]
    logic [87:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    int tx_idle_pct = 14;
    int rx_idle_pct = 83;
    int long_stall_id = 0;

    typedef struct packed {
        bit        acc;
        bit [7:0]  slot;
        bit [31:0] edist;
        bit [31:0] etag;
        bit        evalid;
        bit [8:0]  held;
    } topk_result_t;

    class topk_scoreboard;
        localparam int DEPTH = 256;
        bit [31:0]    kept_dist [DEPTH];
        bit [31:0]    kept_tag [DEPTH];
        int           held;
        bit [8:0]     limit_reg;
        topk_result_t due_q [$];
        int           errors, n_ins, n_rej, n_rd, n_hit, peak;

        function new();
            held = 0;
            limit_reg = 9'd256;
            errors = 0;
            n_ins = 0;
            n_rej = 0;
            n_rd = 0;
            n_hit = 0;
            peak = 0;
        endfunction

        // update the list for one accepted transaction and queue its result
        function void note_input(bit op, bit [31:0] distance, bit [31:0] tag,
                                 bit [7:0] rslot);
            topk_result_t r;
            int lim, pos, top;
            r = '0;
            lim = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : int'(limit_reg));
            if (op == bstr_pkg::OP_INSERT) begin
                n_ins++;
                if (held == 0) begin
                    kept_dist[0] = distance;
                    kept_tag[0] = tag;
                    held = 1;
                    r.acc = 1'b1;
                end
                else if (kept_dist[held-1] <= distance) begin
                    if (held >= lim)
                        n_rej++;
                    else
                    begin
                        kept_dist[held] = distance;
                        kept_tag[held] = tag;
                        r.acc = 1'b1;
                        r.slot = 8'(held);
                        held++;
                    end
                end
                else
                begin
                    // last entry is greater, so the scan stops inside the list
                    pos = 0;
                    while (kept_dist[pos] <= distance)
                        pos++;
                    top = (held < lim) ? held : held - 1;
                    if (held < lim)
                        held++;
                    for (int j = top; j > pos; j--)
                    begin
                        kept_dist[j] = kept_dist[j-1];
                        kept_tag[j] = kept_tag[j-1];
                    end
                    kept_dist[pos] = distance;
                    kept_tag[pos] = tag;
                    r.acc = 1'b1;
                    r.slot = 8'(pos);
                end
            end
            else
            begin
                n_rd++;
                if (rslot < held) begin
                    r.edist = kept_dist[rslot];
                    r.etag = kept_tag[rslot];
                    r.evalid = 1'b1;
                    n_hit++;
                end
            end
            r.held = 9'(held);
            if (held > peak)
                peak = held;
            due_q.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [87:0] m);
            topk_result_t want;
            if (due_q.size() == 0) begin
                $error("result transaction with nothing outstanding: 0x%0h", m);
                errors++;
                return;
            end
            want = due_q.pop_front();
            cmp("accepted", want.acc, m[0]);
            cmp("insert_slot", want.slot, m[8:1]);
            cmp("entry_distance", want.edist, m[40:9]);
            cmp("entry_tag", want.etag, m[72:41]);
            cmp("entry_valid", want.evalid, m[73]);
            cmp("held_count", want.held, m[82:74]);
        endfunction
    endclass

    topk_scoreboard sb = new();

    bounded_sorted_topk_retention DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : rx_side
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_seen != long_stall_id) begin
                stall_seen = long_stall_id;
                stall_left = 60;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic send_item(bit op, bit [31:0] d, bit [31:0] t, bit [7:0] rs);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {rs, t, d};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, d, t, rs);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(bit [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.limit_reg = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count, int read_pct, int pause_at);
        bit        op;
        bit [31:0] d;
        bit [7:0]  rs;
        int        h;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain();
            op = ($urandom_range(0, 99) < read_pct) ? bstr_pkg::OP_READ
                                                    : bstr_pkg::OP_INSERT;
            case ($urandom_range(0, 9))
                0, 1, 2: d = $urandom_range(0, 31) << 16;    // whole values, many ties
                3, 4:    d = ($urandom_range(0, 31) << 16) | $urandom_range(0, 3);
                5:       d = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                default: d = $urandom();
            endcase
            h = sb.held;
            if ($urandom_range(0, 99) < 70)
                rs = $urandom_range(0, (h > 255) ? 255 : h);
            else
                rs = $urandom_range(0, 255);
            send_item(op, d, $urandom(), rs);
        end
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= bstr_pkg::OP_INSERT;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, extremes, ties, limit below the held count
        send_item(bstr_pkg::OP_READ, $urandom(), $urandom(), 8'd0);
        send_item(bstr_pkg::OP_READ, $urandom(), $urandom(), 8'd255);
        send_item(bstr_pkg::OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 8'd0);
        send_item(bstr_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0, 8'hFF);
        send_item(bstr_pkg::OP_INSERT, 32'h0, 32'h0000_1234, 8'd0);
        send_item(bstr_pkg::OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 8'd0);
        send_item(bstr_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 8'd0);
        for (int s = 0; s <= 5; s++)
            send_item(bstr_pkg::OP_READ, $urandom(), $urandom(), 8'(s));
        set_limit(9'd3);
        send_item(bstr_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'd0);
        send_item(bstr_pkg::OP_INSERT, 32'h0000_0010, 32'h0000_0010, 8'd0);
        send_item(bstr_pkg::OP_READ, 32'h0, 32'h0, 8'd4);
        set_limit(9'd0);
        send_item(bstr_pkg::OP_INSERT, 32'h0, 32'hC0DE_0000, 8'd0);
        send_item(bstr_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0002, 8'd0);
        send_item(bstr_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        set_limit(9'd511);
        send_item(bstr_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0003, 8'd0);
        send_item(bstr_pkg::OP_READ, 32'h0, 32'h0, 8'd5);

        set_limit(9'd7);
        run_random(80, 30, -1);

        tx_idle_pct = 83;
        rx_idle_pct = 14;
        set_limit(9'd256);
        run_random(280, 5, 120);

        // no idling; receiver holds off long enough to stall the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_limit(9'd40);
        long_stall_id++;
        run_random(80, 40, -1);

        drain();
        $display("Ran %0d inserts (%0d rejected) and %0d reads (%0d inside the list),",
                 sb.n_ins, sb.n_rej, sb.n_rd, sb.n_hit);
        $display("with keep limits 3, 0, 511, 7, 256 and 40; peak held count %0d.", sb.peak);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
